>>> hw/rtl/smti_pkg.sv
// ----------------------------------------------------------------------------
// smti_pkg
// Shared constants, breakpoint tables and control types for the soil
// moisture table interpolator.
// ----------------------------------------------------------------------------
package smti_pkg;

  localparam int TABLE_SLOTS = 21;
  localparam int IDX_W       = 5;   // indexes the 21-entry table
  localparam int CODE_W      = 12;  // converter reading width
  localparam int PCT_W       = 7;   // 0..100 percent
  localparam int SPAN_W      = 8;   // widest segment is 137 codes
  localparam int REM_W       = 11;  // 10*diff + span <= 1507
  localparam int DVS_W       = SPAN_W + 1;
  localparam int Q_W         = 3;   // rounded quotient is at most 5
  localparam int CNT_W       = 2;   // counts the three quotient bits

  localparam logic [CODE_W-1:0] KNOT_CODE [TABLE_SLOTS] = '{
    12'd2019, 12'd2020, 12'd2029, 12'd2044, 12'd2067, 12'd2097, 12'd2134,
    12'd2178, 12'd2230, 12'd2288, 12'd2354, 12'd2426, 12'd2506, 12'd2593,
    12'd2687, 12'd2788, 12'd2896, 12'd3011, 12'd3134, 12'd3263, 12'd3400
  };

  localparam logic [PCT_W-1:0] KNOT_PCT [TABLE_SLOTS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // Breakpoint code; slots past the table read as zero
  function automatic logic [CODE_W-1:0] knot_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    code = '0;
    if (int'(idx) < TABLE_SLOTS) begin
      code = KNOT_CODE[idx];
    end
    return code;
  endfunction

  // Breakpoint percent; slots past the table read as zero
  function automatic logic [PCT_W-1:0] knot_pct(input logic [IDX_W-1:0] idx);
    logic [PCT_W-1:0] pct;
    pct = '0;
    if (int'(idx) < TABLE_SLOTS) begin
      pct = KNOT_PCT[idx];
    end
    return pct;
  endfunction

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture the reading, restart the search
    logic search_step;  // advance the segment index
    logic prep;         // set up dividend and divisor
    logic div_step;     // resolve one quotient bit
    logic finish;       // write the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_of_range; // reading lies outside the table
    logic search_more;  // current breakpoint is still below the reading
    logic trivial;      // segment needs no division
    logic div_last;     // last quotient bit in progress
    logic out_free;     // result register can take a new item
  } dp_status_t;

endpackage

>>> hw/rtl/smti_dpath.sv
// ----------------------------------------------------------------------------
// smti_dpath
// Datapath: reading register, segment index, restoring divider for the
// rounded interpolation term and the result register.
// ----------------------------------------------------------------------------
module smti_dpath #(
  parameter int USED_POINTS = 21
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [smti_pkg::CODE_W-1:0] in_raw,
  input  smti_pkg::ctrl_cmd_t         cmd,
  output smti_pkg::dp_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [smti_pkg::PCT_W-1:0]  out_pct
);
  import smti_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED_POINTS - 1);

  logic [CODE_W-1:0] raw_q;
  logic [IDX_W-1:0]  k;
  logic [REM_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [Q_W-1:0]    q;
  logic [CNT_W-1:0]  cnt;
  logic              trivial;

  logic [CODE_W-1:0] hi_code;
  logic [CODE_W-1:0] lo_code;
  logic [SPAN_W-1:0] diff;
  logic [SPAN_W-1:0] span;
  logic [REM_W-1:0]  shifted;
  logic              below;
  logic              above;

  // Segment bounds and range checks
  always_comb begin
    hi_code = knot_code(k);
    lo_code = knot_code(k - IDX_W'(1));
    diff    = SPAN_W'(hi_code - raw_q);
    span    = SPAN_W'(hi_code - lo_code);
    below   = raw_q < knot_code('0);
    above   = raw_q > knot_code(LAST_IDX);
    shifted = REM_W'(dvs) << cnt;
  end

  assign status.out_of_range = below || above;
  assign status.search_more  = (k < LAST_IDX) && (hi_code < raw_q);
  assign status.trivial      = trivial;
  assign status.div_last     = (cnt == '0);
  assign status.out_free     = !out_valid || out_ready;

  // Search index and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      if (cmd.load) begin
        raw_q <= in_raw;
        k     <= '0;
      end
      if (cmd.search_step) begin
        k <= k + IDX_W'(1);
      end
      if (cmd.prep) begin
        // dividend 2*5*diff + span, divisor 2*span
        rem     <= REM_W'(({4'd0, diff} * 12'd10) + {4'd0, span});
        dvs     <= {span, 1'b0};
        q       <= '0;
        cnt     <= CNT_W'(Q_W - 1);
        trivial <= (k == '0) || (span == '0);
      end
      if (cmd.div_step) begin
        if (rem >= shifted) begin
          rem    <= rem - shifted;
          q[cnt] <= 1'b1;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (below) begin
        out_pct <= PCT_FULL;
      end else if (above) begin
        out_pct <= PCT_EMPTY;
      end else begin
        out_pct <= knot_pct(k) + PCT_W'(q);
      end
    end
  end

  // Search never runs past the last breakpoint in use
  assert property (@(posedge clk) disable iff (rst) k <= LAST_IDX)
    else $error("segment index past last breakpoint");

  // A division step always sees a nonzero divisor
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> dvs != '0)
    else $error("division step with zero divisor");

  // Interpolated results never exceed full scale
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out_pct <= PCT_FULL)
    else $error("result above 100 percent");

endmodule

>>> hw/rtl/smti_ctrl.sv
// ----------------------------------------------------------------------------
// smti_ctrl
// Controller: sequences capture, breakpoint search, division and result
// write for one item at a time.
// ----------------------------------------------------------------------------
module smti_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smti_pkg::dp_status_t status,
  output smti_pkg::ctrl_cmd_t  cmd
);
  import smti_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.out_of_range) begin
          state_next = ST_FINISH;
        end else if (status.search_more) begin
          cmd.search_step = 1'b1;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.trivial) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A captured item is always followed by the search
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == ST_SEARCH)
    else $error("capture not followed by search");

  // Division only ever follows setup or a prior division step
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> ($past(state) == ST_PREP || $past(state) == ST_DIV))
    else $error("division step without setup");

  // Result write returns the controller to idle
  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> in_ready)
    else $error("controller not idle after result write");

endmodule

>>> hw/rtl/soil_moisture_table_interpolator_core.sv
// ----------------------------------------------------------------------------
// soil_moisture_table_interpolator_core
// Converts a 12-bit soil probe reading into moisture percent by piecewise
// linear interpolation over a fixed breakpoint table.
// ----------------------------------------------------------------------------
// Sequence: accept, serial breakpoint search (one breakpoint per cycle),
//   divider setup, division steps, result write. Readings outside the
//   table go from the search straight to the result write; a segment
//   that needs no division skips the division steps. A still unaccepted
//   earlier result holds off the result write.
// Throughput: one item at a time; a waiting result does not block the next
//   accept, but the search plus the 3-step divider sets the item interval.
// Reset: rst clears the controller to idle and drops the result valid.
// ----------------------------------------------------------------------------
module soil_moisture_table_interpolator_core #(
  parameter int BREAKPOINTS = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] raw_reading, [15:12] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [6:0] moisture_percent, [7] zero
);
  import smti_pkg::*;

  localparam int USED_POINTS = (BREAKPOINTS < 2) ? 2 :
                               ((BREAKPOINTS > TABLE_SLOTS) ? TABLE_SLOTS : BREAKPOINTS);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [PCT_W-1:0]  out_pct;

  smti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  smti_dpath #(
    .USED_POINTS (USED_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_raw    (s_axis_tdata[CODE_W-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pct   (out_pct)
  );

  assign m_axis_tdata = {1'b0, out_pct};

  // Accepting an item makes the block busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready after accept");

  // A fresh result only appears at the end of a busy period
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item in progress");

  // Padding bit of the result stays clear
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> !m_axis_tdata[7])
    else $error("result padding bit set");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the soil moisture table interpolator. It feeds
// probe readings over the input stream, predicts each moisture percent from
// its own copy of the breakpoint table, and checks the output stream in order.
// It runs directed corners first, then random readings under varied back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import smti_pkg::*;

  localparam int NUM_POINTS   = 21;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 175;

  // Breakpoint table, rising codes with falling percent
  localparam int MOIST_CODE [NUM_POINTS] = '{
    2019, 2020, 2029, 2044, 2067, 2097, 2134, 2178, 2230, 2288, 2354,
    2426, 2506, 2593, 2687, 2788, 2896, 3011, 3134, 3263, 3400
  };
  localparam int MOIST_PCT [NUM_POINTS] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0
  };

  typedef struct {
    logic [CODE_W-1:0] raw;
    logic [PCT_W-1:0]  pct;
  } moisture_entry_t;

  // Holds predicted percents in accept order and checks results against them
  class moisture_scoreboard;
    moisture_entry_t pending[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [PCT_W-1:0] predict_percent(logic [CODE_W-1:0] raw);
      int k;
      int hi;
      int lo;
      int span;
      int q;
      int r;
      r = int'(raw);
      if (r < MOIST_CODE[0]) return PCT_FULL;
      if (r > MOIST_CODE[NUM_POINTS-1]) return PCT_EMPTY;
      k = 0;
      while (k < NUM_POINTS - 1 && MOIST_CODE[k] < r) k++;
      if (k == 0) return PCT_W'(MOIST_PCT[0]);
      hi = MOIST_CODE[k];
      lo = MOIST_CODE[k-1];
      span = hi - lo;
      if (span == 0) return PCT_W'(MOIST_PCT[k]);
      // round half up: (2*5*(hi-raw) + span) / (2*span)
      q = (10 * (hi - r) + span) / (2 * span);
      return PCT_W'(MOIST_PCT[k] + q);
    endfunction

    function void note_reading(logic [CODE_W-1:0] raw);
      moisture_entry_t e;
      e.raw = raw;
      e.pct = predict_percent(raw);
      pending.push_back(e);
    endfunction

    function void check_percent(logic [PCT_W-1:0] got);
      moisture_entry_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: percent %0d with nothing pending", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e.pct) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: reading %0d expected %0d got %0d", e.raw, e.pct, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] raw_reading, [15:12] zero
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [6:0] moisture_percent, [7] zero

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  moisture_scoreboard board = new();

  soil_moisture_table_interpolator_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note accepted readings, then check accepted results
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      board.note_reading(s_axis_tdata[CODE_W-1:0]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_percent(m_axis_tdata[PCT_W-1:0]);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one reading and hold it until the block takes it
  task automatic send_reading(input logic [CODE_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Mostly in-table readings, some hugging breakpoints, the rest anywhere
  function automatic logic [CODE_W-1:0] pick_reading();
    int sel;
    int idx;
    sel = $urandom_range(99);
    if (sel < 65)
      return CODE_W'($urandom_range(MOIST_CODE[NUM_POINTS-1], MOIST_CODE[0]));
    if (sel < 80) begin
      idx = $urandom_range(NUM_POINTS - 1);
      return CODE_W'(MOIST_CODE[idx] + $urandom_range(2) - 1);
    end
    return CODE_W'($urandom_range(4095));
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_reading(pick_reading());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, both sides of the table edges, every breakpoint
    send_reading(12'd0);
    send_reading(12'd4095);
    send_reading(12'd2018);
    send_reading(12'd3401);
    for (int i = 0; i < NUM_POINTS; i++) send_reading(CODE_W'(MOIST_CODE[i]));

    // Random readings under each back-pressure mix
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(81, 0, PHASE_ITEMS);
    run_phase(0, 81, PHASE_ITEMS);
    run_phase(11, 11, PHASE_ITEMS);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow stray results to show up
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
